// File: rtl/core/rtucrc_pkg.sv
package rtucrc_pkg;

  localparam int unsigned LenW  = 9;
  localparam int unsigned CrcW  = 16;
  localparam int unsigned ByteW = 8;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_UNSUP   = 2'd2;

  // frame side selections
  localparam logic SIDE_REQUEST  = 1'b0;
  localparam logic SIDE_RESPONSE = 1'b1;

  // read codes whose response carries a byte count
  localparam logic [7:0] FC_READ_COILS      = 8'h01;
  localparam logic [7:0] FC_READ_INPUT_REGS = 8'h04;

  // write and exception function codes; only the multi writes carry a byte count
  localparam logic [7:0] FC_WR_MULTI_COILS = 8'h0F;
  localparam logic [7:0] FC_WR_MULTI_REGS  = 8'h10;
  localparam logic [7:0] FC_WR_COIL        = 8'h05;
  localparam logic [7:0] FC_WR_REG         = 8'h06;
  localparam logic [7:0] FC_EXC_LO         = 8'h81;
  localparam logic [7:0] FC_EXC_HI         = 8'h86;
  localparam logic [7:0] FC_EXC_MULTI_COIL = 8'h8F;
  localparam logic [7:0] FC_EXC_MULTI_REG  = 8'h90;

  localparam logic [CrcW-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CrcW-1:0] CRC_POLY = 16'hA001;

  // one result item
  typedef struct packed {
    logic [1:0]       status;
    logic [LenW-1:0]  length;
    logic [ByteW-1:0] address;
    logic [ByteW-1:0] func;
    logic [CrcW-1:0]  crc;
  } rtucrc_result_t;

  // reflected crc table entry, a 256-entry constant table
  function automatic logic [CrcW-1:0] crc_tab(input logic [ByteW-1:0] idx);
    logic [CrcW-1:0] c;
    c = {8'h00, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // one table step; the value is held with the first sent byte in the high half
  function automatic logic [CrcW-1:0] crc_step(input logic [CrcW-1:0] v,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] s;
    logic [CrcW-1:0] r;
    s = {v[7:0], v[15:8]};
    r = {8'h00, s[15:8]} ^ crc_tab(s[7:0] ^ b);
    return {r[7:0], r[15:8]};
  endfunction

endpackage

// File: rtl/core/rtucrc_parser.sv
module rtucrc_parser
  import rtucrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 side,
  input  logic                 restart_req,
  input  logic                 fire,
  input  logic [ByteW-1:0]     data_byte,
  output logic                 report,
  output rtucrc_result_t       result
);

  logic [LenW-1:0]  pos, pos_next;
  logic [CrcW-1:0]  crc, crc_next;
  logic [LenW-1:0]  exp_len, exp_len_next;
  logic [ByteW-1:0] addr, addr_next;
  logic [ByteW-1:0] func, func_next;
  logic [ByteW-1:0] ftb, ftb_next;

  logic [CrcW-1:0]  crc_b;
  logic             fc_short_req;
  logic             fc_count;
  logic             fc_fixed_rsp;
  logic             fc_exc;
  logic             body_en;
  logic [LenW-1:0]  body_len;
  logic [LenW:0]    pos_p2;
  logic [LenW:0]    len_w;

  // one crc step over the incoming byte
  assign crc_b = crc_step(crc, data_byte);

  // function code classes
  assign fc_short_req = (func >= FC_READ_COILS) && (func <= FC_WR_REG);
  assign fc_count     = (func == FC_WR_MULTI_COILS) || (func == FC_WR_MULTI_REGS);
  assign fc_fixed_rsp = (func == FC_WR_COIL) || (func == FC_WR_REG) || fc_count;
  assign fc_exc       = ((func >= FC_EXC_LO) && (func <= FC_EXC_HI)) ||
                        (func == FC_EXC_MULTI_COIL) || (func == FC_EXC_MULTI_REG);

  // frame length in force for this byte
  always_comb begin
    if (exp_len != '0) begin
      body_len = exp_len;
    end else if (fc_short_req) begin
      body_len = LenW'(8);
    end else begin
      body_len = LenW'(9) + LenW'(ftb);
    end
  end

  assign pos_p2 = {1'b0, pos} + (LenW+1)'(2);
  assign len_w  = {1'b0, body_len};

  // request header is complete at byte 7 with a known code
  assign body_en = (exp_len != '0) ||
                   ((side == SIDE_REQUEST) && (pos == LenW'(7)) &&
                    (fc_short_req || fc_count));

  // next state and report
  always_comb begin
    pos_next     = pos;
    crc_next     = crc;
    exp_len_next = exp_len;
    addr_next    = addr;
    func_next    = func;
    ftb_next     = ftb;
    report       = 1'b0;
    result       = '{status: ST_OK, length: body_len, address: addr,
                     func: func, crc: crc};
    if (fire) begin
      if (body_en) begin
        exp_len_next = body_len;
        if (pos_p2 < len_w) begin
          crc_next = crc_b;
          pos_next = pos + LenW'(1);
        end else if (pos_p2 == len_w) begin
          ftb_next = data_byte;
          pos_next = pos + LenW'(1);
        end else begin
          report        = 1'b1;
          result.status = ((ftb == crc[15:8]) && (data_byte == crc[7:0])) ?
                          ST_OK : ST_CRC_ERR;
        end
      end else if (side == SIDE_REQUEST) begin
        if (pos == LenW'(0)) addr_next = data_byte;
        if (pos == LenW'(1)) func_next = data_byte;
        if (pos < LenW'(6)) begin
          crc_next = crc_b;
          pos_next = pos + LenW'(1);
        end else if (pos == LenW'(6)) begin
          // byte count of a multi write is part of the crc
          ftb_next = data_byte;
          pos_next = LenW'(7);
          if (fc_count) crc_next = crc_b;
        end else begin
          report        = 1'b1;
          result.status = ST_UNSUP;
          result.length = LenW'(8);
        end
      end else begin
        crc_next = crc_b;
        if (pos == LenW'(0)) addr_next = data_byte;
        if (pos == LenW'(1)) func_next = data_byte;
        if (pos < LenW'(2)) begin
          pos_next = pos + LenW'(1);
        end else begin
          pos_next = LenW'(3);
          if ((func >= FC_READ_COILS) && (func <= FC_READ_INPUT_REGS)) begin
            exp_len_next = LenW'(5) + LenW'(data_byte);
          end else if (fc_fixed_rsp) begin
            exp_len_next = LenW'(8);
          end else if (fc_exc) begin
            exp_len_next = LenW'(5);
          end else begin
            report        = 1'b1;
            result.status = ST_UNSUP;
            result.length = LenW'(3);
            result.crc    = crc_b;
          end
        end
      end
      if (report) begin
        pos_next     = '0;
        crc_next     = CRC_INIT;
        exp_len_next = '0;
      end
    end
    if (restart_req) begin
      pos_next     = '0;
      crc_next     = CRC_INIT;
      exp_len_next = '0;
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      crc     <= CRC_INIT;
      exp_len <= '0;
      addr    <= '0;
      func    <= '0;
      ftb     <= '0;
    end else begin
      pos     <= pos_next;
      crc     <= crc_next;
      exp_len <= exp_len_next;
      addr    <= addr_next;
      func    <= func_next;
      ftb     <= ftb_next;
    end
  end

endmodule

// File: rtl/core/rtu_frame_delimiter_crc_check_unit.sv
// channel  | direction | handshake               | payload
// s_axis   | in        | s_axis_tvalid/tready    | tdata: data_byte
// m_axis   | out       | m_axis_tvalid/tready    | tuser: frame_status; tdata: see port
// cfg      | in        | cfg_valid/cfg_ready     | cfg_data: frame_side
//
// one byte per cycle while no result is stalled: each byte is held in the input register, and the
// frame state and crc step update from it in a single table lookup.
// a result passes through the input register and then the result register before it shows on m_axis.
// a stalled result holds the parser; bytes that give no result pass while m_axis is free.
// rst (synchronous) clears frame state and selects the request side.
module rtu_frame_delimiter_crc_check_unit
  import rtucrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,   // [1:0] frame_status
  output logic [47:0] m_axis_tdata,   // [8:0] frame_length, [16:9] unit_address,
                                      // [24:17] function_code, [40:25] computed_crc
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data        // frame_side
);

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             fire;
  logic             side;
  logic             cfg_we;
  logic             report;
  rtucrc_result_t   result;
  rtucrc_result_t   out_res;
  logic             out_valid;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;

  // parser takes the held byte when the result register can take a result
  assign fire          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  // side register
  always_ff @(posedge clk) begin
    if (rst) begin
      side <= SIDE_REQUEST;
    end else if (cfg_we) begin
      side <= cfg_data;
    end
  end

  rtucrc_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .side        (side),
    .restart_req (cfg_we),
    .fire        (fire),
    .data_byte   (in_byte),
    .report      (report),
    .result      (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && report) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && report) begin
      out_res <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {7'd0, out_res.crc, out_res.func, out_res.address,
                          out_res.length};

endmodule

// File: rtl/core/rtucrc_checker.sv
module rtucrc_checker
  import rtucrc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [1:0]  m_axis_tuser,
  input logic [47:0] m_axis_tdata
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // status is one of the three codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_CRC_ERR ||
                       m_axis_tuser == ST_UNSUP))
    else $error("bad status code");

  // an unsupported code is reported at length 3 on the response side or 8 on the request side
  a_unsup_len: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_UNSUP) |->
      (m_axis_tdata[8:0] == 9'd3 || m_axis_tdata[8:0] == 9'd8))
    else $error("unsupported code reported at wrong length");

  // a checked frame is at least five bytes and at most 264
  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != ST_UNSUP) |->
      (m_axis_tdata[8:0] >= 9'd5 && m_axis_tdata[8:0] <= 9'd264))
    else $error("checked frame length out of range");

endmodule

bind rtu_frame_delimiter_crc_check_unit rtucrc_checker u_rtucrc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tdata  (m_axis_tdata)
);
